// ===== sv/mtf_pkg.sv =====
// shared types, codes and constants of the modbus tcp client framer
package mtf_pkg;

  // input command codes
  typedef enum logic [2:0] {
    CMD_RD_COILS = 3'd0,
    CMD_RD_REGS  = 3'd1,
    CMD_WR_COIL  = 3'd2,
    CMD_WR_REG   = 3'd3,
    CMD_RESP     = 3'd4
  } cmd_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_REQ    = 2'd0,
    KIND_COIL   = 2'd1,
    KIND_WORD   = 2'd2,
    KIND_STATUS = 2'd3
  } kind_e;

  // frame status codes
  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_BAD_LEN  = 2'd1,
    STS_EXC      = 2'd2,
    STS_MISMATCH = 2'd3
  } status_e;

  // work handed from the parser to the emitter
  typedef enum logic [1:0] {
    JOB_NONE = 2'd0,
    JOB_REQ  = 2'd1,
    JOB_COIL = 2'd2,
    JOB_WORD = 2'd3
  } job_e;

  localparam logic [7:0] FC_READ_COILS      = 8'h01;
  localparam logic [7:0] FC_READ_INPUT_REGS = 8'h04;
  localparam logic [7:0] FC_WRITE_COIL      = 8'h05;
  localparam logic [7:0] FC_WRITE_REG       = 8'h06;
  localparam logic [7:0] EXC_BIT            = 8'h80;
  localparam logic [7:0] MAX_LEN            = 8'd253;
  localparam logic [7:0] MIN_LEN            = 8'd2;
  localparam logic [7:0] COIL_ON            = 8'hFF;
  localparam logic [7:0] MBAP_LEN_LO        = 8'd6;
  localparam logic [3:0] REQ_BYTES          = 4'd12;

  // response header byte positions
  localparam logic [8:0] IDX_LEN_HI = 9'd4;
  localparam logic [8:0] IDX_LEN_LO = 9'd5;
  localparam logic [8:0] IDX_UNIT   = 9'd6;
  localparam logic [8:0] IDX_PDU    = 9'd7;
  localparam logic [8:0] IDX_MAX    = 9'd511;

  // request byte positions
  localparam logic [3:0] RB_TID_HI  = 4'd0;
  localparam logic [3:0] RB_TID_LO  = 4'd1;
  localparam logic [3:0] RB_LEN_LO  = 4'd5;
  localparam logic [3:0] RB_UNIT    = 4'd6;
  localparam logic [3:0] RB_FC      = 4'd7;
  localparam logic [3:0] RB_ADDR_HI = 4'd8;
  localparam logic [3:0] RB_ADDR_LO = 4'd9;
  localparam logic [3:0] RB_OPER_HI = 4'd10;
  localparam logic [3:0] RB_OPER_LO = 4'd11;

  typedef struct packed {
    job_e        jtype;
    logic [15:0] tid;
    logic [7:0]  unit;
    logic [7:0]  fc;
    logic [15:0] addr;
    logic [15:0] oper;
    logic [3:0]  ncoil;
    logic        has_status;
    status_e     status;
  } job_t;

  function automatic logic [7:0] fc_of_cmd(input logic [1:0] cmd);
    logic [7:0] fc;
    case (cmd)
      2'd0:    fc = FC_READ_COILS;
      2'd1:    fc = FC_READ_INPUT_REGS;
      2'd2:    fc = FC_WRITE_COIL;
      default: fc = FC_WRITE_REG;
    endcase
    return fc;
  endfunction

endpackage

// ===== sv/mtf_front.sv =====
// front end: accepts commands and response bytes, tracks the frame, issues jobs
module mtf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        cmd_i,
  input  logic [15:0]       address_i,
  input  logic [15:0]       operand_i,
  input  logic [7:0]        rx_byte_i,
  output logic              push_o,
  output mtf_pkg::job_t     job_o,
  input  logic              full_i
);

  logic [7:0]  unit_q;
  logic [15:0] tc_q, tc_d;
  logic        pend_q, pend_d;
  logic [1:0]  pcmd_q, pcmd_d;
  logic [15:0] qty_q, qty_d;
  logic [8:0]  idx_q, idx_d;
  logic [7:0]  plen_q, plen_d;
  logic [7:0]  bc_q, bc_d;
  logic [15:0] ce_q, ce_d;
  logic [7:0]  hold_q, hold_d;
  mtf_pkg::status_e err_q, err_d;

  logic        acc;
  logic        is_read;
  logic [7:0]  pfc;
  logic [8:0]  p;
  logic [8:0]  d;
  logic [15:0] rem;
  logic [3:0]  ncoil;
  mtf_pkg::status_e err_n;

  assign in_ready_o = !full_i;
  assign acc        = in_valid_i && !full_i;
  assign is_read    = (pcmd_q == 2'd0) || (pcmd_q == 2'd1);
  assign pfc        = mtf_pkg::fc_of_cmd(pcmd_q);
  assign p          = idx_q - mtf_pkg::IDX_PDU;
  assign d          = p - 9'd2;
  assign rem        = qty_q - ce_q;
  assign ncoil      = (rem > 16'd7) ? 4'd8 : rem[3:0];

  always_comb begin
    tc_d   = tc_q;
    pend_d = pend_q;
    pcmd_d = pcmd_q;
    qty_d  = qty_q;
    idx_d  = idx_q;
    plen_d = plen_q;
    bc_d   = bc_q;
    ce_d   = ce_q;
    hold_d = hold_q;
    err_d  = err_q;
    err_n  = err_q;
    job_o  = '0;
    job_o.jtype  = mtf_pkg::JOB_NONE;
    job_o.status = mtf_pkg::STS_OK;
    push_o = 1'b0;
    if (acc) begin
      case (cmd_i)
        mtf_pkg::CMD_RD_COILS, mtf_pkg::CMD_RD_REGS,
        mtf_pkg::CMD_WR_COIL, mtf_pkg::CMD_WR_REG: begin
          tc_d         = tc_q + 16'd1;
          job_o.jtype  = mtf_pkg::JOB_REQ;
          job_o.tid    = tc_q + 16'd1;
          job_o.unit   = unit_q;
          job_o.fc     = mtf_pkg::fc_of_cmd(cmd_i[1:0]);
          job_o.addr   = address_i;
          if (cmd_i == mtf_pkg::CMD_WR_COIL) begin
            job_o.oper = (operand_i != 16'd0) ? {mtf_pkg::COIL_ON, 8'h00} : 16'h0000;
          end else begin
            job_o.oper = operand_i;
          end
          push_o = 1'b1;
          pend_d = 1'b1;
          pcmd_d = cmd_i[1:0];
          qty_d  = (cmd_i[1] == 1'b0) ? operand_i : 16'd0;
          idx_d  = '0;
          plen_d = '0;
          bc_d   = '0;
          ce_d   = '0;
          hold_d = '0;
          err_d  = mtf_pkg::STS_OK;
        end
        mtf_pkg::CMD_RESP: begin
          if (pend_q) begin
            if (idx_q != mtf_pkg::IDX_MAX) begin
              idx_d = idx_q + 9'd1;
            end
            if (idx_q == mtf_pkg::IDX_LEN_HI) begin
              hold_d = rx_byte_i;
            end else if (idx_q == mtf_pkg::IDX_LEN_LO) begin
              if (hold_q != 8'd0 || rx_byte_i < mtf_pkg::MIN_LEN ||
                  rx_byte_i > mtf_pkg::MAX_LEN) begin
                err_d  = mtf_pkg::STS_BAD_LEN;
                plen_d = '0;
              end else begin
                plen_d = rx_byte_i - 8'd1;
              end
              hold_d = '0;
            end else if (idx_q == mtf_pkg::IDX_UNIT) begin
              if (err_q == mtf_pkg::STS_BAD_LEN) begin
                job_o.has_status = 1'b1;
                job_o.status     = mtf_pkg::STS_BAD_LEN;
                push_o           = 1'b1;
                pend_d           = 1'b0;
              end
            end else if (idx_q >= mtf_pkg::IDX_PDU) begin
              if (p == 9'd0) begin
                // function byte checks
                if ((rx_byte_i & mtf_pkg::EXC_BIT) != 8'd0) begin
                  err_n = mtf_pkg::STS_EXC;
                end else if (rx_byte_i != pfc) begin
                  err_n = mtf_pkg::STS_MISMATCH;
                end else if (is_read && plen_q < 8'd2) begin
                  err_n = mtf_pkg::STS_MISMATCH;
                end
              end else if (err_q == mtf_pkg::STS_OK && is_read) begin
                if (p == 9'd1) begin
                  bc_d = rx_byte_i;
                  if ({1'b0, rx_byte_i} + 9'd2 > {1'b0, plen_q}) begin
                    err_n = mtf_pkg::STS_MISMATCH;
                  end
                end else if (d < {1'b0, bc_q}) begin
                  if (pcmd_q == 2'd0) begin
                    ce_d = ce_q + {12'd0, ncoil};
                    if (ncoil != 4'd0) begin
                      job_o.jtype = mtf_pkg::JOB_COIL;
                      job_o.ncoil = ncoil;
                      job_o.oper  = {8'h00, rx_byte_i};
                    end
                  end else if (!d[0]) begin
                    hold_d = rx_byte_i;
                  end else begin
                    job_o.jtype = mtf_pkg::JOB_WORD;
                    job_o.oper  = {hold_q, rx_byte_i};
                  end
                end
              end
              err_d = err_n;
              // last pdu byte closes the frame
              if ({1'b0, p} + 10'd1 >= {2'b00, plen_q}) begin
                job_o.has_status = 1'b1;
                job_o.status     = err_n;
                pend_d           = 1'b0;
              end
              push_o = (job_o.jtype != mtf_pkg::JOB_NONE) || job_o.has_status;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= 8'd1;
      tc_q   <= '0;
      pend_q <= 1'b0;
      pcmd_q <= '0;
      qty_q  <= '0;
      idx_q  <= '0;
      plen_q <= '0;
      bc_q   <= '0;
      ce_q   <= '0;
      hold_q <= '0;
      err_q  <= mtf_pkg::STS_OK;
    end else begin
      if (cfg_we_i) begin
        unit_q <= cfg_wdata_i;
      end
      tc_q   <= tc_d;
      pend_q <= pend_d;
      pcmd_q <= pcmd_d;
      qty_q  <= qty_d;
      idx_q  <= idx_d;
      plen_q <= plen_d;
      bc_q   <= bc_d;
      ce_q   <= ce_d;
      hold_q <= hold_d;
      err_q  <= err_d;
    end
  end

endmodule

// ===== sv/mtf_queue.sv =====
// two-entry job queue between parser and emitter
module mtf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mtf_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output mtf_pkg::job_t job_o,
  output logic          empty_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);

  mtf_pkg::job_t    mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== sv/mtf_back.sv =====
// back end: expands queued jobs into result transfers through an output register
module mtf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mtf_pkg::job_t job_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    kind_o,
  output logic [15:0]   data_o,
  output logic [1:0]    status_o,
  output logic          last_o
);

  logic [3:0]  cnt_q, cnt_d;
  logic        vld_q, vld_d;
  mtf_pkg::kind_e kind_q, kind_d;
  logic [15:0] data_q, data_d;
  mtf_pkg::status_e sts_q, sts_d;
  logic        last_q, last_d;

  logic        advance;
  logic        emit;
  logic [3:0]  total;
  logic        final_step;
  logic [7:0]  req_byte;
  logic        in_body;

  assign advance = !vld_q || out_ready_i;
  assign emit    = advance && !empty_i;

  always_comb begin
    case (job_i.jtype)
      mtf_pkg::JOB_REQ:  total = mtf_pkg::REQ_BYTES;
      mtf_pkg::JOB_COIL: total = job_i.ncoil + {3'd0, job_i.has_status};
      mtf_pkg::JOB_WORD: total = 4'd1 + {3'd0, job_i.has_status};
      default:           total = 4'd1;
    endcase
  end

  assign final_step = (cnt_q == total - 4'd1);
  assign in_body    = (job_i.jtype == mtf_pkg::JOB_COIL) ? (cnt_q < job_i.ncoil)
                    : (job_i.jtype == mtf_pkg::JOB_WORD) ? (cnt_q == 4'd0) : 1'b0;

  always_comb begin
    case (cnt_q)
      mtf_pkg::RB_TID_HI:  req_byte = job_i.tid[15:8];
      mtf_pkg::RB_TID_LO:  req_byte = job_i.tid[7:0];
      mtf_pkg::RB_LEN_LO:  req_byte = mtf_pkg::MBAP_LEN_LO;
      mtf_pkg::RB_UNIT:    req_byte = job_i.unit;
      mtf_pkg::RB_FC:      req_byte = job_i.fc;
      mtf_pkg::RB_ADDR_HI: req_byte = job_i.addr[15:8];
      mtf_pkg::RB_ADDR_LO: req_byte = job_i.addr[7:0];
      mtf_pkg::RB_OPER_HI: req_byte = job_i.oper[15:8];
      mtf_pkg::RB_OPER_LO: req_byte = job_i.oper[7:0];
      default:             req_byte = 8'h00;
    endcase
  end

  always_comb begin
    cnt_d  = cnt_q;
    vld_d  = vld_q && !out_ready_i;
    kind_d = kind_q;
    data_d = data_q;
    sts_d  = sts_q;
    last_d = last_q;
    pop_o  = 1'b0;
    if (emit) begin
      vld_d = 1'b1;
      if (job_i.jtype == mtf_pkg::JOB_REQ) begin
        kind_d = mtf_pkg::KIND_REQ;
        data_d = {8'h00, req_byte};
        sts_d  = mtf_pkg::STS_OK;
        last_d = final_step;
      end else if (in_body && job_i.jtype == mtf_pkg::JOB_COIL) begin
        kind_d = mtf_pkg::KIND_COIL;
        data_d = {15'd0, job_i.oper[cnt_q[2:0]]};
        sts_d  = mtf_pkg::STS_OK;
        last_d = 1'b0;
      end else if (in_body) begin
        kind_d = mtf_pkg::KIND_WORD;
        data_d = job_i.oper;
        sts_d  = mtf_pkg::STS_OK;
        last_d = 1'b0;
      end else begin
        kind_d = mtf_pkg::KIND_STATUS;
        data_d = 16'd0;
        sts_d  = job_i.status;
        last_d = 1'b1;
      end
      if (final_step) begin
        pop_o = 1'b1;
        cnt_d = '0;
      end else begin
        cnt_d = cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      vld_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    data_q <= data_d;
    sts_q  <= sts_d;
    last_q <= last_d;
  end

  assign out_valid_o = vld_q;
  assign kind_o      = kind_q;
  assign data_o      = data_q;
  assign status_o    = sts_q;
  assign last_o      = last_q;

endmodule

// ===== sv/modbus_tcp_client_framer.sv =====
// top level of the modbus tcp client framer: parser, job queue and emitter
//
// channel   dir  bits                               meaning
// s_axis    in   tuser[2:0] command                 request command or response byte
//                tdata[39:0] address,operand,rx_byte
// m_axis    out  tuser[1:0] kind, tlast last        request bytes, coils, words, status
//                tdata[23:0] data,status
// cfg       in   cfg_wdata_i[7:0] unit_id           written when cfg_we_i is high
//
// the parser takes one item per cycle while the job queue has room
// the emitter sends one result per cycle while a job is queued and the output is ready:
// a request expands to 12 byte results, a coil byte up to 9 with the closing status
// so the emitter sets sustained rate, one result per clock while the output is ready
// reset clears all frame tracking, the transaction counter and sets unit_id to 1
// an output stall holds the result register; the parser keeps going until the queue fills
module modbus_tcp_client_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,    // unit_id
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // address[15:0], operand[31:16], rx_byte[39:32]
  input  logic [2:0]  s_axis_tuser,   // command[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // data[15:0], status[17:16], zero[23:18]
  output logic [1:0]  m_axis_tuser,   // kind[1:0]
  output logic        m_axis_tlast
);

  mtf_pkg::job_t fr_job;
  mtf_pkg::job_t bk_job;
  logic          push;
  logic          full;
  logic          pop;
  logic          empty;
  logic [15:0]   out_data;
  logic [1:0]    out_status;

  // parser: frame state and request builder
  mtf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (s_axis_tuser),
    .address_i   (s_axis_tdata[15:0]),
    .operand_i   (s_axis_tdata[31:16]),
    .rx_byte_i   (s_axis_tdata[39:32]),
    .push_o      (push),
    .job_o       (fr_job),
    .full_i      (full)
  );

  // decouples parsing from result expansion
  mtf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (fr_job),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (bk_job),
    .empty_o (empty)
  );

  // emitter: one result transfer per cycle while a job is queued and the output is ready
  mtf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (bk_job),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .kind_o      (m_axis_tuser),
    .data_o      (out_data),
    .status_o    (out_status),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, out_status, out_data};

  // only status results carry a nonzero status
  a_status_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != mtf_pkg::KIND_STATUS) |-> out_status == 2'd0)
    else $error("nonzero status on a data result");

  // a status result always closes the frame
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == mtf_pkg::KIND_STATUS) |-> m_axis_tlast)
    else $error("status result without last");

  // coil and word results never end a frame
  a_data_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |->
      (m_axis_tuser == mtf_pkg::KIND_REQ) || (m_axis_tuser == mtf_pkg::KIND_STATUS))
    else $error("last set on coil or word result");

  // the parser never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("job pushed into full queue");

endmodule
